// ===== rtl/core/fca_pkg.sv =====
// Package for the allocation-table block: table geometry, entry encoding,
// command, status and sequencer codes. Depends on nothing.
package fca_pkg;

  localparam int NUM_BLOCKS = 2048;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int ENT_W      = BLK_W + 1;        // end flag on top of a block index
  localparam int FIRST_DATA = 2;

  // Stored entry: {end, index}. All zero is the free mark.
  localparam logic [ENT_W-1:0] ENT_FREE = '0;
  localparam logic [ENT_W-1:0] ENT_END  = {1'b1, {BLK_W{1'b0}}};

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_LINK  = 2'd1,
    MODE_NEXT  = 2'd2,
    MODE_FREE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_FULL          = 3'd1,
    ST_RANGE         = 3'd2,
    ST_FREE_IN_CHAIN = 3'd3,
    ST_RESERVED      = 3'd4,
    ST_BAD_PTR       = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_LINK,
    S_NEXT,
    S_FREE
  } state_t;

endpackage

// ===== rtl/core/fat_chain_allocator.sv =====
// Top level of the allocation-table block: table memory, sequencer, free
// count and result register. Depends on fca_pkg.
//
// Block allocation table with one command per transaction. The table sits in
// one 2048 x 12 synchronous RAM (end flag plus successor index) and every
// command that reaches it reads an entry, one entry per cycle; all but
// next-in-chain write it back. After reset a clearing pass writes the reset
// marks to all NUM_BLOCKS (2048) entries; input stays stalled until it ends.
// Disk full and range/reserved-start errors load the output register straight
// from acceptance; link and next-in-chain do one RAM read, then the check
// (and, for link, the write-back); allocate scans entries upward from the
// lowest block that may be free (a hint register kept by free, link and
// allocate); free-chain walks one pointer per cycle through the single RAM
// read port. One command is in flight at a time; the next is taken as soon
// as the sequencer is idle and the result register is empty or draining.
// A running free count replaces any counting scan and is reported with
// every result.
module fat_chain_allocator (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               mode,
  input  logic [fca_pkg::BLK_W-1:0] block,
  input  logic [fca_pkg::BLK_W-1:0] link_target,
  input  logic                     link_is_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output fca_pkg::status_t         status,
  output logic [fca_pkg::BLK_W-1:0] block_out,
  output logic                     chain_end,
  output logic [fca_pkg::BLK_W-1:0] free_count
);
  import fca_pkg::*;

  localparam logic [BLK_W-1:0] FIRST_IDX = BLK_W'(FIRST_DATA);
  localparam logic [BLK_W:0]   NUM_W     = (BLK_W+1)'(NUM_BLOCKS);
  localparam logic [BLK_W-1:0] LAST_IDX  = BLK_W'(NUM_BLOCKS - 1);

  // Table RAM with one write and one read port, registered read.
  logic [ENT_W-1:0] mem [NUM_BLOCKS];
  logic             rd_en, wr_en;
  logic [BLK_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data, fwd_data, ent;
  logic             fwd;

  // Sequencer and datapath registers.
  state_t           state, state_next;
  logic [BLK_W-1:0] clr, clr_next;     // clearing pass address
  logic [BLK_W-1:0] ptr, ptr_next;     // entry being worked on
  logic [BLK_W:0]   hint, hint_next;   // every data block below this is in use
  logic [BLK_W-1:0] cnt, cnt_next;     // free data blocks
  logic [BLK_W-1:0] op_target;
  logic             op_end;

  // Result staging.
  logic             res_load;
  status_t          res_status;
  logic [BLK_W-1:0] res_bout;
  logic             res_cend;

  logic accept;
  mode_t in_mode;

  // Decodes shared by next-state and datapath logic.
  logic             blk_ok, blk_rsvd, cnt_zero;
  logic             ent_free, ent_end, ent_bad, ent_rsvd;
  logic [BLK_W-1:0] ent_idx;
  logic [ENT_W-1:0] link_ent;

  assign in_mode  = mode_t'(mode);
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign blk_ok   = {1'b0, block} < NUM_W;
  assign blk_rsvd = block < FIRST_IDX;
  assign cnt_zero = (cnt == '0);

  // A read of the entry written in the same cycle takes the new value.
  assign ent      = fwd ? fwd_data : rd_data;
  assign ent_free = (ent == ENT_FREE);
  assign ent_end  = ent[BLK_W];
  assign ent_idx  = ent[BLK_W-1:0];
  assign ent_bad  = !ent_end && ({1'b0, ent_idx} >= NUM_W);
  assign ent_rsvd = ent_idx < FIRST_IDX;
  assign link_ent = op_end ? ENT_END : {1'b0, op_target};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      fwd     <= wr_en && (wr_addr == rd_addr);
    end
    fwd_data <= wr_data;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_ALLOC: if (!cnt_zero) state_next = S_ALLOC;
            MODE_LINK:  if (blk_ok) state_next = S_LINK;
            MODE_NEXT:  if (blk_ok) state_next = S_NEXT;
            MODE_FREE:  if (blk_ok && !blk_rsvd) state_next = S_FREE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (ent_free) state_next = S_IDLE;
      end
      S_LINK, S_NEXT: begin
        state_next = S_IDLE;
      end
      S_FREE: begin
        if (ent_end || ent_bad || ent_rsvd) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory control, counters and results.
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = ENT_FREE;
    clr_next   = clr;
    ptr_next   = ptr;
    hint_next  = hint;
    cnt_next   = cnt;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_bout   = '0;
    res_cend   = 1'b0;

    unique case (state)
      S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr;
        wr_data  = (clr < FIRST_IDX) ? ENT_END : ENT_FREE;
        clr_next = BLK_W'(clr + 1'b1);
      end

      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_ALLOC: begin
              if (cnt_zero) begin
                res_load   = 1'b1;
                res_status = ST_FULL;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = hint[BLK_W-1:0];
                ptr_next = hint[BLK_W-1:0];
              end
            end
            MODE_LINK, MODE_NEXT: begin
              if (!blk_ok) begin
                res_load   = 1'b1;
                res_status = ST_RANGE;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = block;
                ptr_next = block;
              end
            end
            MODE_FREE: begin
              if (!blk_ok) begin
                res_load   = 1'b1;
                res_status = ST_RANGE;
              end else if (blk_rsvd) begin
                res_load   = 1'b1;
                res_status = ST_RESERVED;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = block;
                ptr_next = block;
              end
            end
            default: ;
          endcase
        end
      end

      S_ALLOC: begin
        // hint guarantees a free entry at or above ptr
        if (ent_free) begin
          wr_en     = 1'b1;
          wr_addr   = ptr;
          wr_data   = ENT_END;
          cnt_next  = BLK_W'(cnt - 1'b1);
          hint_next = (BLK_W+1)'({1'b0, ptr} + 1'b1);
          res_load  = 1'b1;
          res_bout  = ptr;
        end else begin
          ptr_next = BLK_W'(ptr + 1'b1);
          rd_en    = 1'b1;
          rd_addr  = BLK_W'(ptr + 1'b1);
        end
      end

      S_LINK: begin
        wr_en    = 1'b1;
        wr_addr  = ptr;
        wr_data  = link_ent;
        res_load = 1'b1;
        // reserved blocks are written but not counted
        if (ptr >= FIRST_IDX) begin
          if (ent_free && (link_ent != ENT_FREE) && !cnt_zero) begin
            cnt_next = BLK_W'(cnt - 1'b1);
          end else if (!ent_free && (link_ent == ENT_FREE)) begin
            cnt_next = BLK_W'(cnt + 1'b1);
            if ({1'b0, ptr} < hint) hint_next = {1'b0, ptr};
          end
        end
      end

      S_NEXT: begin
        res_load = 1'b1;
        if (ent_free) begin
          res_status = ST_FREE_IN_CHAIN;
        end else if (ptr < FIRST_IDX) begin
          res_status = ST_RESERVED;
        end else if (ent_end) begin
          res_cend = 1'b1;
        end else if (ent_bad) begin
          res_status = ST_BAD_PTR;
        end else begin
          res_bout = ent_idx;
        end
      end

      S_FREE: begin
        // Free this entry, then follow its old successor. A free entry reads
        // as successor 0 and stops the walk as reserved, so a loop in the
        // chain ends within one revisit and no visit bound is needed.
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_data = ENT_FREE;
        if (!ent_free) cnt_next = BLK_W'(cnt + 1'b1);
        if ({1'b0, ptr} < hint) hint_next = {1'b0, ptr};
        if (ent_end) begin
          res_load = 1'b1;
        end else if (ent_bad) begin
          res_load   = 1'b1;
          res_status = ST_BAD_PTR;
        end else if (ent_rsvd) begin
          res_load   = 1'b1;
          res_status = ST_RESERVED;
        end else begin
          ptr_next = ent_idx;
          rd_en    = 1'b1;
          rd_addr  = ent_idx;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      hint  <= (BLK_W+1)'(FIRST_DATA);
      cnt   <= BLK_W'(NUM_BLOCKS - FIRST_DATA);
    end else begin
      state <= state_next;
      clr   <= clr_next;
      hint  <= hint_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (accept) begin
      op_target <= link_target;
      op_end    <= link_is_end;
    end
  end

  // Result register: loads only when empty or draining, see in_stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status     <= res_status;
      block_out  <= res_bout;
      chain_end  <= res_cend;
      free_count <= cnt_next;
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for fat_chain_allocator: random and directed table commands
// are checked against a behavioral model of the allocation table kept in this file.
// Depends on fca_pkg and the fat_chain_allocator RTL.
`timescale 1ns / 100ps

module tb;
  import fca_pkg::*;

  // Table encoding used by the bench model: 0 free, all ones end of chain,
  // anything else the successor index.
  localparam logic [15:0] E_FREE = 16'h0000;
  localparam logic [15:0] E_END  = 16'hFFFF;
  localparam int WIN_HI     = 47;        // most chains live in blocks 2..WIN_HI
  localparam int RAND_ITEMS = 740;
  localparam int LONG_LEN   = 32;        // blocks in the closing long chain
  localparam int TAIL       = 64;        // cycles to catch stray results at the end
  localparam int LIMIT      = 8_000_000; // clearing pass + slowest walks and stalls, x4

  typedef struct packed {
    mode_t             op;
    logic [BLK_W-1:0]  blk;
    logic [BLK_W-1:0]  tgt;
    logic              is_end;
  } fat_cmd_t;

  typedef struct packed {
    status_t           st;
    logic [BLK_W-1:0]  nxt;
    logic              ce;
    logic [BLK_W-1:0]  cnt;
  } fat_reply_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b1;
  fat_cmd_t          cur_cmd = '0;
  logic [1:0]        mode;
  logic [BLK_W-1:0]  block;
  logic [BLK_W-1:0]  link_target;
  logic              link_is_end;
  status_t           status;
  logic [BLK_W-1:0]  block_out;
  logic              chain_end;
  logic [BLK_W-1:0]  free_count;

  assign mode        = cur_cmd.op;
  assign block       = cur_cmd.blk;
  assign link_target = cur_cmd.tgt;
  assign link_is_end = cur_cmd.is_end;

  fat_chain_allocator uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .block       (block),
    .link_target (link_target),
    .link_is_end (link_is_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .block_out   (block_out),
    .chain_end   (chain_end),
    .free_count  (free_count)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Table model: the bench's own copy of the allocation table and free count.
  // ---------------------------------------------------------------------------
  logic [15:0] fat_tbl [NUM_BLOCKS];
  int          free_total;

  fat_cmd_t    cmd_q[$];    // commands waiting for the driver
  fat_reply_t  reply_q[$];  // predicted replies, oldest first

  int  n_sent;
  int  n_taken = 0;
  int  n_bad = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  in_calm = 0;
  int  out_calm = 0;
  int  stall_hold = 0;
  bit  in_fire = 1'b0;

  function automatic void fat_reset();
    for (int i = 0; i < NUM_BLOCKS; i++)
      fat_tbl[i] = (i < FIRST_DATA) ? E_END : E_FREE;
    free_total = NUM_BLOCKS - FIRST_DATA;
  endfunction

  // Write one entry; only data blocks count toward the free total.
  function automatic void put_entry(int idx, logic [15:0] val);
    if (idx >= FIRST_DATA) begin
      if (fat_tbl[idx] == E_FREE && val != E_FREE && free_total > 0)
        free_total--;
      else if (fat_tbl[idx] != E_FREE && val == E_FREE)
        free_total++;
    end
    fat_tbl[idx] = val;
  endfunction

  // Apply one command to the model and return the reply it should produce.
  function automatic fat_reply_t fat_exec(fat_cmd_t c);
    fat_reply_t  r;
    int          cur;
    logic [15:0] nxt;
    r = '0;
    r.st = ST_OK;
    case (c.op)
      MODE_ALLOC: begin
        r.st = ST_FULL;
        for (int i = FIRST_DATA; i < NUM_BLOCKS; i++) begin
          if (fat_tbl[i] == E_FREE) begin
            put_entry(i, E_END);
            r.st = ST_OK;
            r.nxt = BLK_W'(i);
            break;
          end
        end
      end
      MODE_LINK: begin
        if (int'(c.blk) >= NUM_BLOCKS)
          r.st = ST_RANGE;
        else
          put_entry(int'(c.blk), c.is_end ? E_END : 16'(c.tgt));  // target 0 frees the entry
      end
      MODE_NEXT: begin
        nxt = fat_tbl[c.blk];
        if (int'(c.blk) >= NUM_BLOCKS)
          r.st = ST_RANGE;
        else if (nxt == E_FREE)
          r.st = ST_FREE_IN_CHAIN;
        else if (c.blk < FIRST_DATA)
          r.st = ST_RESERVED;
        else if (nxt == E_END)
          r.ce = 1'b1;
        else if (int'(nxt) >= NUM_BLOCKS)
          r.st = ST_BAD_PTR;
        else
          r.nxt = BLK_W'(nxt);
      end
      default: begin
        // Free-chain walk: each visited entry is freed before its pointer is
        // judged; a free entry reads as successor 0 and stops on reserved.
        cur = int'(c.blk);
        if (cur >= NUM_BLOCKS) begin
          r.st = ST_RANGE;
        end else begin
          r.st = ST_BAD_PTR;
          for (int v = 0; v <= NUM_BLOCKS; v++) begin
            if (cur < FIRST_DATA) begin
              r.st = ST_RESERVED;
              break;
            end
            nxt = fat_tbl[cur];
            put_entry(cur, E_FREE);
            if (nxt == E_END) begin
              r.st = ST_OK;
              break;
            end
            if (int'(nxt) >= NUM_BLOCKS) begin
              r.st = ST_BAD_PTR;
              break;
            end
            cur = int'(nxt);
          end
        end
      end
    endcase
    r.cnt = BLK_W'(free_total);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push(mode_t op, int b, int t, bit e);
    fat_cmd_t c;
    c.op = op;
    c.blk = BLK_W'(b);
    c.tgt = BLK_W'(t);
    c.is_end = e;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  // Mostly a small window so allocates and chains collide; sometimes anywhere.
  function automatic int pick_blk();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(FIRST_DATA, NUM_BLOCKS - 1);
    return $urandom_range(FIRST_DATA, WIN_HI);
  endfunction

  // Input gap after a transaction: mostly none or short, a few long, with
  // occasional stretches of back-to-back transactions.
  function automatic int pick_gap();
    int r;
    if (in_calm > 0) begin
      in_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      in_calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_chain_seq();
    int links[6];
    int n;
    int r;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++)
      links[k] = pick_blk();
    // build the chain, in either order
    if ($urandom_range(0, 1)) begin
      for (int k = 0; k < n; k++)
        push(MODE_LINK, links[k], (k == n - 1) ? $urandom_range(0, 2047) : links[k + 1],
             k == n - 1);
    end else begin
      for (int k = n - 1; k >= 0; k--)
        push(MODE_LINK, links[k], (k == n - 1) ? $urandom_range(0, 2047) : links[k + 1],
             k == n - 1);
    end
    // follow it, skipping some hops
    for (int k = 0; k < n; k++)
      if ($urandom_range(0, 3) != 0)
        push(MODE_NEXT, links[k], $urandom_range(0, 2047), $urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 70)
      push(MODE_FREE, links[0], $urandom_range(0, 2047), $urandom_range(0, 1));
    else if (r < 85)
      push(MODE_FREE, links[$urandom_range(0, n - 1)], $urandom_range(0, 2047),
           $urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0)
      push(MODE_NEXT, links[0], $urandom_range(0, 2047), $urandom_range(0, 1));
  endfunction

  function automatic void add_noise();
    int r;
    int b;
    r = $urandom_range(0, 9);
    if (r < 3)
      b = $urandom_range(0, 1);
    else if (r < 6)
      b = pick_blk();
    else
      b = $urandom_range(0, 2047);
    push(mode_t'($urandom_range(0, 3)), b,
         ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 2047), $urandom_range(0, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending command at the falling edge once the
  // previous transaction completed; payload holds steady while stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      in_fire = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cur_cmd  <= cmd_q.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output backpressure: short and long stalls, with calm stretches.
  always @(negedge clk) begin
    int r;
    if (!rst) begin
      if (stall_hold > 0) begin
        stall_hold--;
      end else if (out_calm > 0) begin
        out_calm--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          out_calm = $urandom_range(50, 200);
          out_stall <= 1'b0;
        end else if (r < 13) begin
          stall_hold = $urandom_range(10, 40);
          out_stall <= 1'b1;
        end else if (r < 43) begin
          stall_hold = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          stall_hold = $urandom_range(0, 7);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic void flag(string why, fat_reply_t e, fat_reply_t g);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t %s: exp st=%0d blk=%0d end=%0d free=%0d  got st=%0d blk=%0d end=%0d free=%0d",
               $realtime, why, e.st, e.nxt, e.ce, e.cnt, g.st, g.nxt, g.ce, g.cnt);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge check a completed result transaction against
  // the oldest prediction, then predict for a completed command transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fat_reply_t got;
    fat_reply_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {status, block_out, chain_end, free_count};
        if (reply_q.size() == 0) begin
          flag("result with nothing pending", '0, got);
        end else begin
          want = reply_q.pop_front();
          if (got !== want)
            flag("reply mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        reply_q.insert(reply_q.size(), fat_exec(cur_cmd));
        n_taken++;
        in_fire = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed commands, random chain traffic, then one long chain.
  // ---------------------------------------------------------------------------
  initial begin
    int base;
    int r;
    fat_reset();

    // directed: every command, reserved blocks, field extremes
    push(MODE_ALLOC, 0, 0, 0);            // gets block 2
    push(MODE_ALLOC, 2047, 2047, 1);      // gets block 3, inputs ignored
    push(MODE_NEXT, 2, 0, 0);             // end of chain
    push(MODE_LINK, 2, 3, 0);
    push(MODE_NEXT, 2, 2047, 1);          // successor 3
    push(MODE_NEXT, 3, 0, 0);
    push(MODE_LINK, 2047, 2047, 0);       // self loop on the last block
    push(MODE_FREE, 2047, 0, 0);          // revisits a freed entry, ends reserved
    push(MODE_NEXT, 0, 0, 0);             // reserved
    push(MODE_NEXT, 1, 2047, 1);          // reserved
    push(MODE_NEXT, 5, 0, 0);             // free entry
    push(MODE_LINK, 0, 0, 0);             // reserved block written free
    push(MODE_NEXT, 0, 0, 0);             // now reads as free
    push(MODE_LINK, 0, 1234, 1);          // restore end mark
    push(MODE_FREE, 0, 0, 0);
    push(MODE_FREE, 1, 0, 0);
    push(MODE_LINK, 1, 4, 0);
    push(MODE_NEXT, 1, 0, 0);             // still reserved
    push(MODE_LINK, 1, 0, 1);
    push(MODE_FREE, 2, 0, 0);             // 2 -> 3 -> end
    push(MODE_LINK, 4, 2047, 1);          // end mark, target ignored
    push(MODE_LINK, 4, 0, 0);             // link to 0 frees the entry
    push(MODE_LINK, 6, 1, 0);             // chain into a reserved block
    push(MODE_FREE, 6, 0, 0);
    push(MODE_FREE, 9, 0, 0);             // start already free

    // random: mostly well-formed chains with random content, some noise
    base = cmd_q.size();
    while (cmd_q.size() < base + RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        add_chain_seq();
      end else if (r < 75) begin
        repeat ($urandom_range(1, 4)) push(MODE_ALLOC, $urandom_range(0, 2047),
                                           $urandom_range(0, 2047), $urandom_range(0, 1));
        if ($urandom_range(0, 1))
          push(MODE_NEXT, pick_blk(), 0, 0);
      end else begin
        add_noise();
      end
    end

    // one long chain over the low data blocks, freed in a single walk
    for (int i = FIRST_DATA; i < FIRST_DATA + LONG_LEN - 1; i++)
      push(MODE_LINK, i, i + 1, 0);
    push(MODE_LINK, FIRST_DATA + LONG_LEN - 1, 0, 1);
    push(MODE_NEXT, FIRST_DATA, 0, 0);
    push(MODE_FREE, FIRST_DATA, 0, 0);
    push(MODE_ALLOC, 0, 0, 0);
    push(MODE_ALLOC, 0, 0, 0);
    n_sent = cmd_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_taken < n_sent || reply_q.size() != 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (n_bad == 0 && reply_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fca_pkg.sv
rtl/core/fat_chain_allocator.sv
bench/tb.sv
